### rtl/core/bilh_pkg.sv
package bilh_pkg;

   // Field widths of the channels and the configuration port.
   localparam int unsigned LUMA_W     = 8;
   localparam int unsigned INDEX_W    = 6;
   localparam int unsigned COUNT_W    = 18;
   localparam int unsigned DIM_W      = 14;
   localparam int unsigned POS_W      = 13;
   localparam int unsigned CSR_DATA_W = 32;
   localparam int unsigned CSR_ADDR_W = 3;

   // Frame size limits and register reset values.
   localparam int unsigned DIM_MIN      = 3;
   localparam int unsigned DIM_MAX      = 8192;
   localparam int unsigned WIDTH_RESET  = 640;
   localparam int unsigned HEIGHT_RESET = 480;

   localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

   typedef enum logic [0:0] {
      REG_IMAGE_WIDTH  = 1'b0,
      REG_IMAGE_HEIGHT = 1'b1
   } reg_index_type;

   // Frame and crop geometry as held by the register block.
   typedef struct packed {
      logic [DIM_W-1:0]   image_width;
      logic [DIM_W-1:0]   image_height;
      logic [DIM_W-1:0]   crop_width;
      logic [DIM_W-1:0]   crop_height;
      logic [DIM_W-1:0]   crop_left;
      logic [DIM_W-1:0]   crop_top;
      logic [COUNT_W-1:0] total_pixels;
   } geometry_type;

   // Control that travels with one pixel into the counting stage.
   typedef struct packed {
      logic valid;
      logic first;
      logic last;
      logic hit;
   } event_ctl_type;

   function automatic logic [DIM_W-1:0] clamp_dim(input logic [CSR_DATA_W-1:0] value);
      logic [DIM_W-1:0] result;
      if (value < CSR_DATA_W'(DIM_MIN)) begin
         result = DIM_W'(DIM_MIN);
      end else if (value > CSR_DATA_W'(DIM_MAX)) begin
         result = DIM_W'(DIM_MAX);
      end else begin
         result = value[DIM_W-1:0];
      end
      return result;
   endfunction

   function automatic logic [DIM_W-1:0] min_dim(input logic [DIM_W-1:0] a,
                                                input logic [DIM_W-1:0] b);
      return (a < b) ? a : b;
   endfunction

endpackage

### rtl/core/bilh_req_if.sv
interface bilh_req_if;
   import bilh_pkg::*;

   logic              valid;
   logic              ready;
   logic [LUMA_W-1:0] luma;

   modport source (output valid, output luma, input ready);
   modport sink   (input valid, input luma, output ready);
endinterface

### rtl/core/bilh_rsp_if.sv
interface bilh_rsp_if;
   import bilh_pkg::*;

   logic               valid;
   logic               ready;
   logic [INDEX_W-1:0] bin_index;
   logic [COUNT_W-1:0] bin_count;
   logic               last;

   modport source (output valid, output bin_index, output bin_count, output last,
                   input ready);
   modport sink   (input valid, input bin_index, input bin_count, input last,
                   output ready);
endinterface

### rtl/core/border_interior_luma_histogram_core.sv
// Border/interior luminance histogram. Pixels of a frame arrive in raster order, one
// 8-bit luma value per transfer on req_ch, and one pixel is taken every clock cycle.
// Only a centered crop of at most MAX_CROP_WIDTH by MAX_CROP_HEIGHT pixels is used; each
// crop pixel is reduced to its top COLOUR_BITS bits, and each pixel off the crop's edge
// is counted as interior when its four neighbors share its color, as border otherwise.
// A pixel travels through three register stages (position and line-store read,
// classification, count update), and the summary begins once the frame's last pixel
// has passed them. It is 2 * 2^COLOUR_BITS + 1 transfers on rsp_ch: border counts
// by color, interior counts by color, then the crop's interior pixel total, the final
// transfer flagged with last. The summary drains from its own register bank, so the
// next frame streams in while it goes out; only the closing pixel of a frame is held
// off (req_ch.ready low) while the previous summary is still draining. The frame size
// registers sit at byte offsets 0 (width) and 4 (height); values are clamped to 3..8192,
// and any register write restarts the frame at its first pixel.

module border_interior_luma_histogram_core #(
   parameter int unsigned MAX_CROP_WIDTH  = 480,
   parameter int unsigned MAX_CROP_HEIGHT = 480,
   parameter int unsigned COLOUR_BITS     = 4
) (
   input  logic                              clock,
   input  logic                              reset,
   bilh_req_if.sink                          req_ch,
   bilh_rsp_if.source                        rsp_ch,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [bilh_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [bilh_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [bilh_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                              csr_pready
);
   import bilh_pkg::*;

   geometry_type          geom;
   logic                  restart;
   logic                  dump_busy;
   event_ctl_type         ev_ctl;
   logic [COLOUR_BITS:0]  ev_bin;

   // Frame geometry registers, with the crop window derived once per write rather than
   // per pixel, and its pixel total registered from the crop size.
   bilh_csr #(
      .MAX_CROP_WIDTH  (MAX_CROP_WIDTH),
      .MAX_CROP_HEIGHT (MAX_CROP_HEIGHT)
   ) u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .geom        (geom),
      .restart     (restart)
   );

   // Raster position, line store of the two previous crop rows, and the sliding
   // neighborhood that classifies each pixel once its lower neighbor has arrived.
   bilh_front #(
      .MAX_CROP_WIDTH (MAX_CROP_WIDTH),
      .COLOUR_BITS    (COLOUR_BITS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .restart   (restart),
      .geom      (geom),
      .dump_busy (dump_busy),
      .req_ch    (req_ch),
      .ev_ctl    (ev_ctl),
      .ev_bin    (ev_bin)
   );

   // Saturating bin counters, cleared on each frame's first pixel, and the summary bank
   // that is captured at frame end and shifted out one transfer at a time.
   bilh_count #(
      .COLOUR_BITS (COLOUR_BITS)
   ) u_count (
      .clock        (clock),
      .reset        (reset),
      .ev_ctl       (ev_ctl),
      .ev_bin       (ev_bin),
      .total_pixels (geom.total_pixels),
      .dump_busy    (dump_busy),
      .rsp_ch       (rsp_ch)
   );

endmodule

### rtl/core/bilh_csr.sv
module bilh_csr #(
   parameter int unsigned MAX_CROP_WIDTH  = 480,
   parameter int unsigned MAX_CROP_HEIGHT = 480
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [bilh_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input  logic [bilh_pkg::CSR_DATA_W-1:0]      csr_pwdata,
   output logic [bilh_pkg::CSR_DATA_W-1:0]      csr_prdata,
   output logic                                 csr_pready,
   output bilh_pkg::geometry_type               geom,
   output logic                                 restart
);
   import bilh_pkg::*;

   localparam int unsigned CROP_W_RST =
      (MAX_CROP_WIDTH < WIDTH_RESET) ? MAX_CROP_WIDTH : WIDTH_RESET;
   localparam int unsigned CROP_H_RST =
      (MAX_CROP_HEIGHT < HEIGHT_RESET) ? MAX_CROP_HEIGHT : HEIGHT_RESET;
   localparam int unsigned LEFT_RST = (WIDTH_RESET - CROP_W_RST) / 2;
   localparam int unsigned TOP_RST  = (HEIGHT_RESET - CROP_H_RST) / 2;

   localparam logic [DIM_W-1:0] MAX_W_DIM = DIM_W'(MAX_CROP_WIDTH);
   localparam logic [DIM_W-1:0] MAX_H_DIM = DIM_W'(MAX_CROP_HEIGHT);

   logic [DIM_W-1:0]     width_ff, height_ff;
   logic [DIM_W-1:0]     crop_w_ff, crop_h_ff, left_ff, top_ff;
   logic [COUNT_W-1:0]   total_ff, total_in;
   logic [DIM_W-1:0]     wr_value, wr_crop_w, wr_crop_h, wr_left, wr_top;
   logic [2*DIM_W-1:0]   area;
   logic                 write_en;
   reg_index_type        reg_index;

   assign csr_pready = 1'b1;
   assign write_en   = csr_psel && csr_penable && csr_pwrite;
   assign reg_index  = reg_index_type'(csr_paddr[2]);
   assign restart    = write_en;

   // Out-of-range sizes are pinned to the supported range before the crop is derived.
   assign wr_value  = clamp_dim(csr_pwdata);
   assign wr_crop_w = min_dim(wr_value, MAX_W_DIM);
   assign wr_crop_h = min_dim(wr_value, MAX_H_DIM);
   assign wr_left   = DIM_W'((wr_value - wr_crop_w) >> 1);
   assign wr_top    = DIM_W'((wr_value - wr_crop_h) >> 1);

   assign area     = {{DIM_W{1'b0}}, crop_w_ff - DIM_W'(2)} *
                     {{DIM_W{1'b0}}, crop_h_ff - DIM_W'(2)};
   assign total_in = area[COUNT_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= DIM_W'(WIDTH_RESET);
         height_ff <= DIM_W'(HEIGHT_RESET);
         crop_w_ff <= DIM_W'(CROP_W_RST);
         crop_h_ff <= DIM_W'(CROP_H_RST);
         left_ff   <= DIM_W'(LEFT_RST);
         top_ff    <= DIM_W'(TOP_RST);
      end else if (write_en) begin
         case (reg_index)
            REG_IMAGE_WIDTH: begin
               width_ff  <= wr_value;
               crop_w_ff <= wr_crop_w;
               left_ff   <= wr_left;
            end
            REG_IMAGE_HEIGHT: begin
               height_ff <= wr_value;
               crop_h_ff <= wr_crop_h;
               top_ff    <= wr_top;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      total_ff <= total_in;
   end

   always_comb begin
      case (reg_index)
         REG_IMAGE_WIDTH:  csr_prdata = {{(CSR_DATA_W-DIM_W){1'b0}}, width_ff};
         REG_IMAGE_HEIGHT: csr_prdata = {{(CSR_DATA_W-DIM_W){1'b0}}, height_ff};
         default:          csr_prdata = '0;
      endcase
   end

   always_comb begin
      geom.image_width  = width_ff;
      geom.image_height = height_ff;
      geom.crop_width   = crop_w_ff;
      geom.crop_height  = crop_h_ff;
      geom.crop_left    = left_ff;
      geom.crop_top     = top_ff;
      geom.total_pixels = total_ff;
   end

   a_crop_inside_width: assert property (@(posedge clock) disable iff (reset)
      ({1'b0, left_ff} + {1'b0, crop_w_ff}) <= {1'b0, width_ff})
      else $error("crop window exceeds the frame width");

endmodule

### rtl/core/bilh_front.sv
module bilh_front #(
   parameter int unsigned MAX_CROP_WIDTH = 480,
   parameter int unsigned COLOUR_BITS    = 4
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    restart,
   input  bilh_pkg::geometry_type  geom,
   input  logic                    dump_busy,
   bilh_req_if.sink                req_ch,
   output bilh_pkg::event_ctl_type ev_ctl,
   output logic [COLOUR_BITS:0]    ev_bin
);
   import bilh_pkg::*;

   localparam int unsigned ADDR_W = (MAX_CROP_WIDTH > 1) ? $clog2(MAX_CROP_WIDTH) : 1;
   localparam int unsigned WORD_W = 2 * COLOUR_BITS;

   logic [POS_W-1:0]       col_ff, col_in, row_ff, row_in;
   logic [DIM_W-1:0]       col_ext, row_ext, col_rel, row_rel;
   logic                   col_last, row_last, frame_last, accept;
   logic                   in_window, cls_ok, first_pix;
   logic [COLOUR_BITS-1:0] colour;
   logic [ADDR_W-1:0]      rd_addr;

   // Each line word holds the colors of the two previous window rows at one column.
   logic [WORD_W-1:0]      line_mem [MAX_CROP_WIDTH];
   logic [WORD_W-1:0]      rd_word_ff;

   logic                   s1_valid_ff, s1_win_ff, s1_cls_ff, s1_first_ff, s1_last_ff;
   logic [COLOUR_BITS-1:0] s1_colour_ff;
   logic [ADDR_W-1:0]      s1_addr_ff;

   logic [COLOUR_BITS-1:0] left_ff, centre_ff, up_ff, down_ff;
   logic [COLOUR_BITS-1:0] above, above2;
   logic                   interior;

   event_ctl_type          ev_ctl_ff, ev_ctl_in;
   logic [COLOUR_BITS:0]   ev_bin_ff, ev_bin_in;

   assign colour  = req_ch.luma[LUMA_W-1 -: COLOUR_BITS];
   assign col_ext = {{(DIM_W-POS_W){1'b0}}, col_ff};
   assign row_ext = {{(DIM_W-POS_W){1'b0}}, row_ff};
   assign col_rel = col_ext - geom.crop_left;
   assign row_rel = row_ext - geom.crop_top;

   assign col_last   = (col_ext + DIM_W'(1)) >= geom.image_width;
   assign row_last   = (row_ext + DIM_W'(1)) >= geom.image_height;
   assign frame_last = col_last && row_last;
   assign first_pix  = (col_ff == '0) && (row_ff == '0);

   // The closing pixel of a frame waits while the previous summary is still going out.
   assign req_ch.ready = !(dump_busy && frame_last);
   assign accept       = req_ch.valid && req_ch.ready;

   assign in_window = (col_ext >= geom.crop_left) && (col_rel < geom.crop_width) &&
                      (row_ext >= geom.crop_top) && (row_rel < geom.crop_height);
   assign cls_ok    = in_window && (col_rel >= DIM_W'(2)) && (row_rel >= DIM_W'(2));
   assign rd_addr   = col_rel[ADDR_W-1:0];

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (restart) begin
         col_in = '0;
         row_in = '0;
      end else if (accept) begin
         if (col_last) begin
            col_in = '0;
            row_in = row_last ? '0 : row_ff + POS_W'(1);
         end else begin
            col_in = col_ff + POS_W'(1);
         end
      end
   end

   // A pixel is classified one column late: the window center is the previous row's
   // pixel left of the column now being read.
   assign above    = rd_word_ff[WORD_W-1 -: COLOUR_BITS];
   assign above2   = rd_word_ff[COLOUR_BITS-1:0];
   assign interior = (left_ff == centre_ff) && (above == centre_ff) &&
                     (up_ff == centre_ff) && (down_ff == centre_ff);

   always_comb begin
      ev_ctl_in.valid = s1_valid_ff;
      ev_ctl_in.first = s1_first_ff;
      ev_ctl_in.last  = s1_last_ff;
      ev_ctl_in.hit   = s1_valid_ff && s1_cls_ff;
      ev_bin_in       = {interior, centre_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff      <= '0;
         row_ff      <= '0;
         s1_valid_ff <= 1'b0;
         ev_ctl_ff   <= '0;
      end else begin
         col_ff      <= col_in;
         row_ff      <= row_in;
         s1_valid_ff <= accept;
         ev_ctl_ff   <= ev_ctl_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_win_ff    <= in_window;
         s1_cls_ff    <= cls_ok;
         s1_first_ff  <= first_pix;
         s1_last_ff   <= frame_last;
         s1_colour_ff <= colour;
         s1_addr_ff   <= rd_addr;
      end
      if (s1_valid_ff && s1_win_ff) begin
         left_ff   <= centre_ff;
         centre_ff <= above;
         up_ff     <= above2;
         down_ff   <= s1_colour_ff;
      end
      ev_bin_ff <= ev_bin_in;
   end

   always_ff @(posedge clock) begin
      if (s1_valid_ff && s1_win_ff) begin
         line_mem[s1_addr_ff] <= {s1_colour_ff, above};
      end
      if (accept && in_window) begin
         rd_word_ff <= line_mem[rd_addr];
      end
   end

   assign ev_ctl = ev_ctl_ff;
   assign ev_bin = ev_bin_ff;

   a_hit_needs_item: assert property (@(posedge clock) disable iff (reset)
      ev_ctl_ff.hit |-> ev_ctl_ff.valid)
      else $error("classification event without a pixel");

endmodule

### rtl/core/bilh_count.sv
module bilh_count #(
   parameter int unsigned COLOUR_BITS = 4
) (
   input  logic                           clock,
   input  logic                           reset,
   input  bilh_pkg::event_ctl_type        ev_ctl,
   input  logic [COLOUR_BITS:0]           ev_bin,
   input  logic [bilh_pkg::COUNT_W-1:0]   total_pixels,
   output logic                           dump_busy,
   bilh_rsp_if.source                     rsp_ch
);
   import bilh_pkg::*;

   localparam int unsigned NUM_COLOURS = 1 << COLOUR_BITS;
   localparam int unsigned NUM_BINS    = 2 * NUM_COLOURS;
   localparam int unsigned NUM_WORDS   = NUM_BINS + 1;
   localparam int unsigned IDX_W       = $clog2(NUM_WORDS);
   localparam int unsigned BIN_W       = COLOUR_BITS + 1;

   logic [COUNT_W-1:0] count_ff [NUM_BINS];
   logic [COUNT_W-1:0] count_in [NUM_BINS];
   logic [COUNT_W-1:0] dump_ff  [NUM_WORDS];
   logic [IDX_W-1:0]   idx_ff;
   logic               busy_ff;
   logic               load, transfer, last_word;

   always_comb begin
      for (int k = 0; k < NUM_BINS; k++) begin
         count_in[k] = count_ff[k];
         if (ev_ctl.valid && ev_ctl.first) begin
            count_in[k] = '0;
         end else if (ev_ctl.hit && (ev_bin == BIN_W'(k)) && (count_ff[k] != COUNT_MAX)) begin
            count_in[k] = count_ff[k] + COUNT_W'(1);
         end
      end
   end

   // The summary is captured from the counts including the closing pixel's own event.
   assign load      = ev_ctl.valid && ev_ctl.last;
   assign last_word = (idx_ff == IDX_W'(NUM_BINS));
   assign transfer  = busy_ff && rsp_ch.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         idx_ff  <= '0;
         for (int k = 0; k < NUM_BINS; k++) begin
            count_ff[k] <= '0;
         end
      end else begin
         for (int k = 0; k < NUM_BINS; k++) begin
            count_ff[k] <= count_in[k];
         end
         if (load) begin
            busy_ff <= 1'b1;
            idx_ff  <= '0;
         end else if (transfer) begin
            if (last_word) begin
               busy_ff <= 1'b0;
            end
            idx_ff <= idx_ff + IDX_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         for (int k = 0; k < NUM_BINS; k++) begin
            dump_ff[k] <= count_in[k];
         end
         dump_ff[NUM_BINS] <= total_pixels;
      end else if (transfer) begin
         for (int k = 0; k < NUM_WORDS - 1; k++) begin
            dump_ff[k] <= dump_ff[k+1];
         end
      end
   end

   assign dump_busy        = busy_ff;
   assign rsp_ch.valid     = busy_ff;
   assign rsp_ch.bin_index = INDEX_W'(idx_ff);
   assign rsp_ch.bin_count = dump_ff[0];
   assign rsp_ch.last      = last_word;

   a_no_load_while_busy: assert property (@(posedge clock) disable iff (reset)
      load |-> !busy_ff)
      else $error("summary captured while the previous one is still draining");

   a_index_in_range: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (idx_ff <= IDX_W'(NUM_BINS)))
      else $error("summary word index out of range");

   a_idle_after_last: assert property (@(posedge clock) disable iff (reset)
      (transfer && last_word) |=> !busy_ff)
      else $error("summary still busy after its final word");

   a_frame_clear: assert property (@(posedge clock) disable iff (reset)
      (ev_ctl.valid && ev_ctl.first) |=> (count_ff[0] == '0))
      else $error("histogram not cleared at frame start");

endmodule

### tb/border_interior_luma_histogram_core_test.sv
module border_interior_luma_histogram_core_test;
   import bilh_pkg::*;

   // The block is built with its default geometry; the prediction below uses the same values.
   localparam int unsigned CROP_W        = 480;
   localparam int unsigned CROP_H        = 480;
   localparam int unsigned COLOR_BITS    = 4;
   localparam int unsigned COLOR_COUNT   = 1 << COLOR_BITS;
   localparam int unsigned NUM_BINS      = 2 * COLOR_COUNT;
   localparam int unsigned MAX_IDLE      = 16;
   localparam int unsigned RANDOM_PIXELS = 110;
   // The pipeline is three stages deep; this quiet wait lets it empty before the block
   // can be called idle once the last expected summary word has arrived.
   localparam int unsigned SETTLE_CYCLES = 8;
   // The longest stretch without any transfer in a correct run is a sender gap plus a
   // receiver stall plus the pipeline and settle waits. The limit is taken many times over that.
   localparam int unsigned WATCHDOG_LIMIT = 4000;
   localparam int unsigned DIRECTED_ROWS  = 23;

   // One word of the frame summary as it leaves on the result channel.
   typedef struct packed {
      logic [INDEX_W-1:0] bin_index;
      logic [COUNT_W-1:0] bin_count;
      logic               last;
   } summary_word_type;

   // One row of the directed plan. Where typed is set, the summary that this pixel closes
   // is written out by hand: one nonzero bin, every other bin zero, then the crop total.
   typedef struct packed {
      logic [LUMA_W-1:0]  luma;
      logic               typed;
      logic [INDEX_W-1:0] hot_bin;
      logic [COUNT_W-1:0] hot_count;
      logic [COUNT_W-1:0] crop_total;
      logic               restart;
   } plan_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   bilh_req_if req_ch ();
   bilh_rsp_if rsp_ch ();

   border_interior_luma_histogram_core #(
      .MAX_CROP_WIDTH  (CROP_W),
      .MAX_CROP_HEIGHT (CROP_H),
      .COLOUR_BITS     (COLOR_BITS)
   ) dut (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #5 clock = ~clock;

   // Shadow of the block: frame size registers, raster position, the two line stores of
   // quantized colors and the per-frame bin counts.
   int unsigned        frame_width  = WIDTH_RESET;
   int unsigned        frame_height = HEIGHT_RESET;
   int unsigned        next_col     = 0;
   int unsigned        next_row     = 0;
   logic [COLOR_BITS-1:0] color_rows [2*CROP_W] = '{default: '0};
   logic [COUNT_W-1:0]    bin_tally  [NUM_BINS] = '{default: '0};

   // Summary words that the block still owes, oldest first.
   summary_word_type summary_words_due [$];

   int unsigned failures      = 0;
   int unsigned frames_done   = 0;
   int unsigned pixels_sent   = 0;
   int unsigned words_checked = 0;
   int unsigned quiet_cycles  = 0;
   bit          quiet_source  = 1'b0;
   bit          quiet_sink    = 1'b0;

   // Directed frames at 3 by 3, so that the single center pixel is the only one classified.
   plan_row_type directed_plan [DIRECTED_ROWS] = '{
      // All pixels at full scale: the center is interior in the top color.
      '{8'hFF, 1'b0, 6'd0, 18'd0, 18'd0, 1'b0},
      '{8'hFF, 1'b0, 6'd0, 18'd0, 18'd0, 1'b0},
      '{8'hFF, 1'b0, 6'd0, 18'd0, 18'd0, 1'b0},
      '{8'hFF, 1'b0, 6'd0, 18'd0, 18'd0, 1'b0},
      '{8'hFF, 1'b0, 6'd0, 18'd0, 18'd0, 1'b0},
      '{8'hFF, 1'b0, 6'd0, 18'd0, 18'd0, 1'b0},
      '{8'hFF, 1'b0, 6'd0, 18'd0, 18'd0, 1'b0},
      '{8'hFF, 1'b0, 6'd0, 18'd0, 18'd0, 1'b0},
      '{8'hFF, 1'b1, INDEX_W'(COLOR_COUNT + COLOR_COUNT - 1), 18'd1, 18'd1, 1'b0},
      // Center, left, right and upper neighbors quantize to color zero, the lower one to
      // color one, so the center lands in the border bin of color zero.
      '{8'h00, 1'b0, 6'd0, 18'd0, 18'd0, 1'b0},
      '{8'h0F, 1'b0, 6'd0, 18'd0, 18'd0, 1'b0},
      '{8'hFF, 1'b0, 6'd0, 18'd0, 18'd0, 1'b0},
      '{8'h03, 1'b0, 6'd0, 18'd0, 18'd0, 1'b0},
      '{8'h0C, 1'b0, 6'd0, 18'd0, 18'd0, 1'b0},
      '{8'h01, 1'b0, 6'd0, 18'd0, 18'd0, 1'b0},
      '{8'h80, 1'b0, 6'd0, 18'd0, 18'd0, 1'b0},
      '{8'h10, 1'b0, 6'd0, 18'd0, 18'd0, 1'b0},
      '{8'h7F, 1'b1, 6'd0, 18'd1, 18'd1, 1'b0},
      // A frame cut short: a register write in the middle restarts it at the first pixel.
      '{8'h55, 1'b0, 6'd0, 18'd0, 18'd0, 1'b0},
      '{8'hAA, 1'b0, 6'd0, 18'd0, 18'd0, 1'b0},
      '{8'h5A, 1'b0, 6'd0, 18'd0, 18'd0, 1'b0},
      '{8'hA5, 1'b0, 6'd0, 18'd0, 18'd0, 1'b0},
      '{8'h3C, 1'b0, 6'd0, 18'd0, 18'd0, 1'b1}
   };

   function automatic int unsigned clamp_size(input logic [CSR_DATA_W-1:0] value);
      if (value < DIM_MIN) begin
         return DIM_MIN;
      end
      if (value > DIM_MAX) begin
         return DIM_MAX;
      end
      return int'(value);
   endfunction

   function automatic int unsigned crop_extent(input int unsigned size, input int unsigned limit);
      return (size < limit) ? size : limit;
   endfunction

   function automatic void check_field(input string what, input longint unsigned expected,
                                       input longint unsigned actual);
      if (expected != actual) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, expected, actual);
         failures++;
      end
   endfunction

   // Advances the shadow by one pixel. A pixel is counted once its lower neighbor arrives,
   // so the classification here is of the pixel one row above the incoming one. The
   // counts are cleared on the first pixel of every frame, and the frame closes when the
   // raster position wraps past the last row.
   task automatic take_pixel(input logic [LUMA_W-1:0] luma, output bit frame_done);
      int unsigned           crop_w;
      int unsigned           crop_h;
      int unsigned           crop_left;
      int unsigned           crop_top;
      int unsigned           wi;
      int unsigned           wj;
      int unsigned           slot;
      int unsigned           prev;
      int unsigned           bin;
      logic [COLOR_BITS-1:0] color;
      logic [COLOR_BITS-1:0] above;
      logic [COLOR_BITS-1:0] west;
      logic [COLOR_BITS-1:0] center;
      logic [COLOR_BITS-1:0] east;
      bit                    interior;
      crop_w     = crop_extent(frame_width, CROP_W);
      crop_h     = crop_extent(frame_height, CROP_H);
      crop_left  = (frame_width - crop_w) >> 1;
      crop_top   = (frame_height - crop_h) >> 1;
      color      = luma[LUMA_W-1 -: COLOR_BITS];
      frame_done = 1'b0;
      if (next_col == 0 && next_row == 0) begin
         bin_tally = '{default: '0};
      end
      if (next_row >= crop_top && next_row < crop_top + crop_h &&
          next_col >= crop_left && next_col < crop_left + crop_w) begin
         wi   = next_row - crop_top;
         wj   = next_col - crop_left;
         slot = (wi % 2) * CROP_W + wj;
         // The edge rows and columns of the crop are never classified.
         if (wi >= 2 && wj >= 1 && wj + 2 <= crop_w) begin
            prev     = ((wi - 1) % 2) * CROP_W;
            above    = color_rows[slot];
            west     = color_rows[prev + wj - 1];
            center   = color_rows[prev + wj];
            east     = color_rows[prev + wj + 1];
            interior = (west == center) && (east == center) && (above == center) &&
                       (color == center);
            bin      = (interior ? COLOR_COUNT : 0) + center;
            if (bin_tally[bin] != COUNT_MAX) begin
               bin_tally[bin]++;
            end
         end
         color_rows[slot] = color;
      end
      next_col++;
      if (next_col >= frame_width) begin
         next_col = 0;
         next_row++;
         if (next_row >= frame_height) begin
            next_row   = 0;
            frame_done = 1'b1;
            frames_done++;
         end
      end
   endtask

   // Queues the summary of the frame just closed: border bins, interior bins, crop total.
   function automatic void queue_predicted_summary();
      int unsigned crop_w;
      int unsigned crop_h;
      crop_w = crop_extent(frame_width, CROP_W);
      crop_h = crop_extent(frame_height, CROP_H);
      for (int k = 0; k < NUM_BINS; k++) begin
         summary_words_due.push_back(summary_word_type'{INDEX_W'(k), bin_tally[k], 1'b0});
      end
      summary_words_due.push_back(summary_word_type'{INDEX_W'(NUM_BINS),
                                                     COUNT_W'((crop_h - 2) * (crop_w - 2)),
                                                     1'b1});
   endfunction

   function automatic void queue_typed_summary(input plan_row_type row);
      for (int k = 0; k < NUM_BINS; k++) begin
         summary_words_due.push_back(summary_word_type'{INDEX_W'(k),
            (k == row.hot_bin) ? row.hot_count : COUNT_W'(0), 1'b0});
      end
      summary_words_due.push_back(summary_word_type'{INDEX_W'(NUM_BINS), row.crop_total,
                                                     1'b1});
   endfunction

   // Register write: setup cycle, access cycle, and the register takes the value at the
   // edge that closes the access. Any write restarts the frame.
   task automatic csr_write(input reg_index_type which, input logic [CSR_DATA_W-1:0] value);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {which, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (csr_pready !== 1'b1);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      if (which == REG_IMAGE_WIDTH) begin
         frame_width = clamp_size(value);
      end else begin
         frame_height = clamp_size(value);
      end
      next_col = 0;
      next_row = 0;
   endtask

   // Register read, checked against the shadow copy, clamping included.
   task automatic csr_check(input reg_index_type which);
      logic [CSR_DATA_W-1:0] got;
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= {which, 2'b00};
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (csr_pready !== 1'b1);
      got = csr_prdata;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      check_field(which == REG_IMAGE_WIDTH ? "image_width read" : "image_height read",
                  (which == REG_IMAGE_WIDTH) ? frame_width : frame_height, got);
   endtask

   // Offers one pixel after a drawn gap and waits for its transfer. Valid stays high
   // after the transfer, so back-to-back pixels never see it drop.
   task automatic send_pixel(input logic [LUMA_W-1:0] luma, output bit frame_done);
      int unsigned gap;
      gap = quiet_source ? 0 : $urandom_range(0, MAX_IDLE);
      if (gap != 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.luma  <= luma;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      pixels_sent++;
      take_pixel(luma, frame_done);
   endtask

   // Streams pixels that mostly share one color per frame with random low bits, so that
   // interior pixels are common, mixed with fully random noise for the border cases.
   task automatic stream_pixels(input int unsigned count);
      logic [COLOR_BITS-1:0] base;
      logic [LUMA_W-1:0]     luma;
      bit                    frame_done;
      base = COLOR_BITS'($urandom);
      for (int unsigned k = 0; k < count; k++) begin
         luma = ($urandom_range(0, 3) != 0) ? {base, 4'($urandom)} : LUMA_W'($urandom);
         send_pixel(luma, frame_done);
         if (frame_done) begin
            queue_predicted_summary();
            base = COLOR_BITS'($urandom);
         end
      end
   endtask

   // Drops valid and holds off until every owed summary word has arrived and the pipeline
   // has had time to empty.
   task automatic settle_block();
      req_ch.valid <= 1'b0;
      while (summary_words_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic resize(input logic [CSR_DATA_W-1:0] width_value,
                         input logic [CSR_DATA_W-1:0] height_value);
      settle_block();
      csr_write(REG_IMAGE_WIDTH, width_value);
      csr_write(REG_IMAGE_HEIGHT, height_value);
      csr_check(REG_IMAGE_WIDTH);
      csr_check(REG_IMAGE_HEIGHT);
   endtask

   // Result side: a stall is drawn after each transfer, and ready then stays high until
   // the next word is taken.
   initial begin : summary_sink
      int unsigned stall;
      rsp_ch.ready = 1'b0;
      wait (reset == 1'b0);
      forever begin
         stall = quiet_sink ? 0 : $urandom_range(0, MAX_IDLE);
         if (stall != 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (rsp_ch.valid !== 1'b1);
      end
   end

   // Each summary transfer is compared field by field with the oldest owed word. Signals
   // are read right at the edge, before any of that edge's updates land.
   always @(posedge clock) begin : summary_check
      summary_word_type due;
      if (!reset && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
         if (summary_words_due.size() == 0) begin
            $display("%0t: summary word with none owed, expected nothing, actual bin %0d count %0d",
                     $time, rsp_ch.bin_index, rsp_ch.bin_count);
            failures++;
         end else begin
            due = summary_words_due.pop_front();
            check_field("bin_index", due.bin_index, rsp_ch.bin_index);
            check_field("bin_count", due.bin_count, rsp_ch.bin_count);
            check_field("last", due.last, rsp_ch.last);
            words_checked++;
         end
      end
   end

   // Ends the run if no transfer of any kind happens for too long.
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
          (csr_psel && csr_penable)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no transfer for %0d cycles, %0d summary words still owed",
                     $time, quiet_cycles, summary_words_due.size());
            $display("status: fail");
            $finish;
         end
      end
   end

   initial begin : stimulus
      bit          frame_done;
      int unsigned frames;
      int unsigned full;
      int unsigned pauses;
      int unsigned small_pixels;
      req_ch.valid = 1'b0;
      req_ch.luma  = '0;
      csr_psel     = 1'b0;
      csr_penable  = 1'b0;
      csr_pwrite   = 1'b0;
      csr_paddr    = '0;
      csr_pwdata   = '0;
      pauses       = 0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset values first, then sizes below the minimum, which clamp to three.
      csr_check(REG_IMAGE_WIDTH);
      csr_check(REG_IMAGE_HEIGHT);
      resize(0, 1);

      foreach (directed_plan[r]) begin
         send_pixel(directed_plan[r].luma, frame_done);
         if (frame_done) begin
            if (directed_plan[r].typed) begin
               queue_typed_summary(directed_plan[r]);
            end else begin
               queue_predicted_summary();
            end
         end
         if (directed_plan[r].restart) begin
            settle_block();
            csr_write(REG_IMAGE_HEIGHT, 2);
         end
      end

      // Small random frames. Each phase picks its own size and idling; now and then a
      // frame is cut short by a register write, and the sender at times waits for the
      // whole summary to drain before the next frame.
      small_pixels = pixels_sent;
      while (pixels_sent - small_pixels < RANDOM_PIXELS) begin
         quiet_source = ($urandom_range(0, 3) == 0);
         quiet_sink   = ($urandom_range(0, 3) == 0);
         resize(($urandom_range(0, 4) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 10),
                $urandom_range(3, 6));
         frames = $urandom_range(1, 3);
         for (int unsigned f = 0;
              f < frames && pixels_sent - small_pixels < RANDOM_PIXELS; f++) begin
            full = frame_width * frame_height;
            if ($urandom_range(0, 5) == 0) begin
               stream_pixels($urandom_range(1, full - 1));
               settle_block();
               csr_write(REG_IMAGE_WIDTH, frame_width);
            end
            stream_pixels(full);
            if (pauses == 0 || $urandom_range(0, 3) == 0) begin
               settle_block();
               pauses++;
            end
         end
      end

      // Crops smaller than the frame in each direction, then sizes written above the
      // limit so that they clamp. Only the opening pixels of these frames are sent, and
      // each frame but the last is cut short by the next register write.
      quiet_source = 1'b0;
      quiet_sink   = 1'b0;
      resize(485, 3);
      stream_pixels(4);
      resize(3, 485);
      stream_pixels(4);
      quiet_source = 1'b1;
      quiet_sink   = 1'b1;
      resize(32'hFFFF_FFFF, 9000);
      stream_pixels(4);

      settle_block();
      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("covered %0d frames from %0d pixels, %0d summary words compared,", frames_done,
               pixels_sent, words_checked);
      $display("full frames from 3x3 to 10x6, mid-frame restarts, and clamped sizes up to 8192");
      if (failures == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

### filelist.f
rtl/core/bilh_pkg.sv
rtl/core/bilh_req_if.sv
rtl/core/bilh_rsp_if.sv
rtl/core/bilh_csr.sv
rtl/core/bilh_front.sv
rtl/core/bilh_count.sv
rtl/core/border_interior_luma_histogram_core.sv
tb/border_interior_luma_histogram_core_test.sv
